[sv/stsc_pkg.sv]
// Shared types, token kind codes and character classes for the source token scanner.
package stsc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_INT    = 2'd2;
  localparam logic [1:0] MODE_STRING = 2'd3;

  // token kinds (0..14 are punctuation)
  localparam logic [4:0] KIND_COMMA   = 5'd0;
  localparam logic [4:0] KIND_DOT     = 5'd1;
  localparam logic [4:0] KIND_COLON   = 5'd2;
  localparam logic [4:0] KIND_SEMI    = 5'd3;
  localparam logic [4:0] KIND_LPAREN  = 5'd4;
  localparam logic [4:0] KIND_RPAREN  = 5'd5;
  localparam logic [4:0] KIND_LBRACK  = 5'd6;
  localparam logic [4:0] KIND_RBRACK  = 5'd7;
  localparam logic [4:0] KIND_LBRACE  = 5'd8;
  localparam logic [4:0] KIND_RBRACE  = 5'd9;
  localparam logic [4:0] KIND_BANG    = 5'd10;
  localparam logic [4:0] KIND_ASSIGN  = 5'd11;
  localparam logic [4:0] KIND_MINUS   = 5'd12;
  localparam logic [4:0] KIND_PLUS    = 5'd13;
  localparam logic [4:0] KIND_STAR    = 5'd14;
  localparam logic [4:0] KIND_STRING  = 5'd15;
  localparam logic [4:0] KIND_EOF     = 5'd16;
  localparam logic [4:0] KIND_IDENT   = 5'd17;
  localparam logic [4:0] KIND_INT     = 5'd18;
  localparam logic [4:0] KIND_ILLEGAL = 5'd19;
  localparam logic [4:0] KIND_LET     = 5'd20;
  localparam logic [4:0] KIND_RETURN  = 5'd21;
  localparam logic [4:0] KIND_CONST   = 5'd22;
  localparam logic [4:0] KIND_USE     = 5'd23;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // last six identifier bytes, newest in the low byte
  localparam logic [47:0] KW_LET    = 48'h0000_006C_6574;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;
  localparam logic [47:0] KW_CONST  = 48'h0063_6F6E_7374;
  localparam logic [47:0] KW_USE    = 48'h0000_0075_7365;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
  } tok_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } job_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2C: k = KIND_COMMA;
      8'h2E: k = KIND_DOT;
      8'h3A: k = KIND_COLON;
      8'h3B: k = KIND_SEMI;
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h5B: k = KIND_LBRACK;
      8'h5D: k = KIND_RBRACK;
      8'h7B: k = KIND_LBRACE;
      8'h7D: k = KIND_RBRACE;
      8'h21: k = KIND_BANG;
      8'h3D: k = KIND_ASSIGN;
      8'h2D: k = KIND_MINUS;
      8'h2B: k = KIND_PLUS;
      8'h2A: k = KIND_STAR;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] word_kind(input logic [47:0] kw, input logic too_long);
    logic [4:0] k;
    k = KIND_IDENT;
    if (!too_long) begin
      if (kw == KW_LET) k = KIND_LET;
      else if (kw == KW_RETURN) k = KIND_RETURN;
      else if (kw == KW_CONST) k = KIND_CONST;
      else if (kw == KW_USE) k = KIND_USE;
    end
    return k;
  endfunction

endpackage

[sv/stsc_if.sv]
// Valid/ready channel interfaces for source bytes and tokens.
interface stsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface stsc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

[sv/stsc_front.sv]
// Scanner front end: tracks lexer state per byte and builds the tokens each byte causes.
module stsc_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  input  logic [7:0]       byte_in,
  input  logic             q_ready,
  output logic             job_valid,
  output stsc_pkg::job_t   job
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [1:0]               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] pend_r, pend_nxt;
  logic [47:0]              kw_r, kw_nxt;
  logic                     long_r, long_nxt;

  logic                     accept;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] run_len;
  logic [31:0]              pos_ext;
  logic [31:0]              pend_ext;
  logic [31:0]              len_ext;
  logic                     handle_idle;
  logic                     pre_v, own_v;
  stsc_pkg::tok_t           pre_tok, own_tok;

  assign accept   = byte_valid && q_ready;
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign run_len  = pos_r - pend_r;
  assign pos_ext  = 32'(pos_r);
  assign pend_ext = 32'(pend_r);
  assign len_ext  = 32'(run_len);

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_inc;
    pend_nxt    = pend_r;
    kw_nxt      = kw_r;
    long_nxt    = long_r;
    handle_idle = 1'b1;
    pre_v       = 1'b0;
    own_v       = 1'b0;
    pre_tok     = '0;
    own_tok     = '0;

    // token ended by this byte
    case (mode_r)
      stsc_pkg::MODE_IDENT: begin
        if (stsc_pkg::is_letter(byte_in)) begin
          if (kw_r[47:40] != 8'h00) long_nxt = 1'b1;
          kw_nxt      = {kw_r[39:0], byte_in};
          handle_idle = 1'b0;
        end else begin
          pre_v         = 1'b1;
          pre_tok.kind  = stsc_pkg::word_kind(kw_r, long_r);
          pre_tok.start = pend_ext[15:0];
          pre_tok.len   = len_ext[15:0];
          mode_nxt      = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_INT: begin
        if (stsc_pkg::is_digit(byte_in)) begin
          handle_idle = 1'b0;
        end else begin
          pre_v         = 1'b1;
          pre_tok.kind  = stsc_pkg::KIND_INT;
          pre_tok.start = pend_ext[15:0];
          pre_tok.len   = len_ext[15:0];
          mode_nxt      = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_STRING: begin
        if (byte_in == stsc_pkg::CH_QUOTE || byte_in == stsc_pkg::CH_NUL) begin
          pre_v         = 1'b1;
          pre_tok.kind  = stsc_pkg::KIND_STRING;
          pre_tok.start = pend_ext[15:0];
          pre_tok.len   = len_ext[15:0];
          mode_nxt      = stsc_pkg::MODE_IDLE;
          // closing quote is consumed; end of input still gives eof below
          handle_idle   = (byte_in == stsc_pkg::CH_NUL);
        end else begin
          handle_idle = 1'b0;
        end
      end
      default: ;
    endcase

    // byte's own token, or start of a new run
    if (handle_idle) begin
      if (stsc_pkg::is_space(byte_in)) begin
        own_v = 1'b0;
      end else if (byte_in == stsc_pkg::CH_NUL) begin
        own_v         = 1'b1;
        own_tok.kind  = stsc_pkg::KIND_EOF;
        own_tok.start = pos_ext[15:0];
        own_tok.len   = 16'd0;
        mode_nxt      = stsc_pkg::MODE_IDLE;
        pos_nxt       = '0;
      end else if (byte_in == stsc_pkg::CH_QUOTE) begin
        mode_nxt = stsc_pkg::MODE_STRING;
        pend_nxt = pos_inc;
      end else if (stsc_pkg::is_letter(byte_in)) begin
        mode_nxt = stsc_pkg::MODE_IDENT;
        pend_nxt = pos_r;
        kw_nxt   = {40'd0, byte_in};
        long_nxt = 1'b0;
      end else if (stsc_pkg::is_digit(byte_in)) begin
        mode_nxt = stsc_pkg::MODE_INT;
        pend_nxt = pos_r;
      end else begin
        own_v         = 1'b1;
        own_tok.kind  = stsc_pkg::punct_kind(byte_in);
        own_tok.start = pos_ext[15:0];
        own_tok.len   = 16'd1;
      end
    end
  end

  always_comb begin
    job = '0;
    if (pre_v) begin
      job.tok0 = pre_tok;
      job.tok1 = own_tok;
      job.two  = own_v;
    end else begin
      job.tok0 = own_tok;
    end
    job_valid = accept && (pre_v || own_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stsc_pkg::MODE_IDLE;
      pos_r  <= '0;
      pend_r <= '0;
      kw_r   <= '0;
      long_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
      kw_r   <= kw_nxt;
      long_r <= long_nxt;
    end
  end

endmodule

[sv/stsc_queue.sv]
// Short job queue between the scanner front end and the token serializer.
module stsc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stsc_pkg::job_t push_job,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output stsc_pkg::job_t head_job
);

  localparam int AW = stsc_pkg::QUEUE_AW;

  stsc_pkg::job_t mem [stsc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r, count_nxt;

  assign not_full  = (count_r != (AW+1)'(stsc_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

[sv/stsc_back.sv]
// Token serializer: splits queued jobs into single tokens behind an output register.
module stsc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  stsc_pkg::job_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output stsc_pkg::tok_t out_tok,
  output logic           out_last
);

  logic           out_valid_r;
  stsc_pkg::tok_t out_tok_r;
  logic           out_last_r;
  logic           held_v_r;
  stsc_pkg::tok_t held_tok_r;
  logic           load;

  assign load  = !out_valid_r || out_ready;
  assign q_pop = load && !held_v_r && q_not_empty;

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_v_r    <= 1'b0;
    end else if (load) begin
      if (held_v_r) begin
        out_valid_r <= 1'b1;
        held_v_r    <= 1'b0;
      end else begin
        out_valid_r <= q_not_empty;
        held_v_r    <= q_not_empty && q_head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (held_v_r) begin
        out_tok_r  <= held_tok_r;
        out_last_r <= 1'b1;
      end else begin
        out_tok_r  <= q_head.tok0;
        out_last_r <= !q_head.two;
        held_tok_r <= q_head.tok1;
      end
    end
  end

endmodule

[sv/source_token_scanner.sv]
// Source token scanner top level: byte channel in, token channel out.
// Usage:
//   in_ch carries one source byte per transaction; byte 0 ends the input and
//   brings the scanner back to idle at position 0 after an eof token.
//   out_ch carries one token per transaction: kind, start, length and a flag
//   marking the last token caused by an input byte.
//   The front end is combinational; a byte's tokens pass through the job queue
//   and the output register before reaching out_ch. A byte that ends a word and
//   is itself a token yields two tokens, the word's token first.
//   Input is taken every cycle while the job queue between front end and
//   serializer has room; while out_ch.ready is high the serializer sends one
//   token per cycle: one byte per cycle while bytes average at most one token.
//   When the receiver stalls, the output register holds its token, the queue
//   fills and in_ch.ready drops once it is full.
//   Synchronous active-low reset clears the scanner state, empties the queue
//   and drops out_ch.valid.
module source_token_scanner #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  stsc_in_if.sink           in_ch,
  stsc_out_if.source        out_ch
);

  logic           q_not_full;
  logic           q_not_empty;
  logic           q_pop;
  logic           job_valid;
  stsc_pkg::job_t job;
  stsc_pkg::job_t head_job;
  stsc_pkg::tok_t out_tok;

  assign in_ch.ready = q_not_full;

  stsc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_in    (in_ch.char_byte),
    .q_ready    (q_not_full),
    .job_valid  (job_valid),
    .job        (job)
  );

  stsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_job  (job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  stsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_tok     (out_tok),
    .out_last    (out_ch.last_of_run)
  );

  assign out_ch.token_kind   = out_tok.kind;
  assign out_ch.token_start  = out_tok.start;
  assign out_ch.token_length = out_tok.len;

endmodule

[tb/stsc_token_checker.sv]
// Token checker: predicts the scanner's tokens from observed byte transactions and compares.
`timescale 1ns / 100ps
module stsc_token_checker (
  input  logic clk,
  input  logic rst_n,
  stsc_in_if   in_mon,
  stsc_out_if  out_mon,
  output int   failures,
  output int   waiting_tokens
);

  typedef struct {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  token_t      due_tokens[$];
  logic [1:0]  scan_state;
  logic [15:0] byte_pos;
  logic [15:0] word_start;
  logic [47:0] recent_chars;
  logic        overlong;
  string       punct_set = ",.:;()[]{}!=-+*";

  function automatic logic is_word_char(input logic [7:0] c);
    // folding bit 5 maps upper case onto lower case
    return ((c | 8'h20) inside {["a":"z"]}) || (c == "_");
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {stsc_pkg::CH_SPACE, stsc_pkg::CH_TAB, stsc_pkg::CH_LF, stsc_pkg::CH_CR};
  endfunction

  // position counter sticks at all ones
  function automatic logic [15:0] advance(input logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  // punctuation kinds follow the order of punct_set
  function automatic logic [4:0] symbol_kind(input logic [7:0] c);
    for (int i = 0; i < punct_set.len(); i++)
      if (punct_set[i] == c) return 5'(i);
    return stsc_pkg::KIND_ILLEGAL;
  endfunction

  function automatic logic [4:0] word_token_kind();
    if (overlong) return stsc_pkg::KIND_IDENT;
    case (recent_chars)
      stsc_pkg::KW_LET:    return stsc_pkg::KIND_LET;
      stsc_pkg::KW_RETURN: return stsc_pkg::KIND_RETURN;
      stsc_pkg::KW_CONST:  return stsc_pkg::KIND_CONST;
      stsc_pkg::KW_USE:    return stsc_pkg::KIND_USE;
      default:             return stsc_pkg::KIND_IDENT;
    endcase
  endfunction

  task automatic queue_token(input logic [4:0] k, input logic [15:0] s, input logic [15:0] l);
    token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    due_tokens.push_back(t);
  endtask

  task automatic scan_byte(input logic [7:0] c);
    logic [15:0] p;
    logic        fresh;
    int          first;
    p     = byte_pos;
    fresh = 1'b1;
    first = due_tokens.size();
    case (scan_state)
      stsc_pkg::MODE_IDENT: begin
        if (is_word_char(c)) begin
          if (recent_chars[47:40] != 8'd0) overlong = 1'b1;
          recent_chars = {recent_chars[39:0], c};
          fresh = 1'b0;
        end else begin
          queue_token(word_token_kind(), word_start, p - word_start);
          scan_state = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_INT: begin
        if (is_numeral(c)) begin
          fresh = 1'b0;
        end else begin
          queue_token(stsc_pkg::KIND_INT, word_start, p - word_start);
          scan_state = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_STRING: begin
        // closing quote is consumed; end of input still gets its own eof below
        if (c == stsc_pkg::CH_QUOTE || c == stsc_pkg::CH_NUL) begin
          queue_token(stsc_pkg::KIND_STRING, word_start, p - word_start);
          scan_state = stsc_pkg::MODE_IDLE;
        end
        if (c != stsc_pkg::CH_NUL) fresh = 1'b0;
      end
      default: ;
    endcase
    byte_pos = advance(p);
    if (fresh && !is_blank(c)) begin
      if (c == stsc_pkg::CH_NUL) begin
        queue_token(stsc_pkg::KIND_EOF, p, 16'd0);
        scan_state = stsc_pkg::MODE_IDLE;
        byte_pos   = '0;
      end else if (c == stsc_pkg::CH_QUOTE) begin
        scan_state = stsc_pkg::MODE_STRING;
        word_start = advance(p);
      end else if (is_word_char(c)) begin
        scan_state   = stsc_pkg::MODE_IDENT;
        word_start   = p;
        recent_chars = {40'd0, c};
        overlong     = 1'b0;
      end else if (is_numeral(c)) begin
        scan_state = stsc_pkg::MODE_INT;
        word_start = p;
      end else begin
        queue_token(symbol_kind(c), p, 16'd1);
      end
    end
    if (due_tokens.size() > first) due_tokens[$].last = 1'b1;
  endtask

  task automatic check_token();
    token_t t;
    if (due_tokens.size() == 0) begin
      $error("unexpected token: kind %0d start %0d length %0d", out_mon.token_kind,
             out_mon.token_start, out_mon.token_length);
      failures++;
    end else begin
      t = due_tokens.pop_front();
      if (out_mon.token_kind !== t.kind) begin
        $error("token_kind: expected %0d, got %0d", t.kind, out_mon.token_kind);
        failures++;
      end
      if (out_mon.token_start !== t.start) begin
        $error("token_start: expected %0d, got %0d", t.start, out_mon.token_start);
        failures++;
      end
      if (out_mon.token_length !== t.len) begin
        $error("token_length: expected %0d, got %0d", t.len, out_mon.token_length);
        failures++;
      end
      if (out_mon.last_of_run !== t.last) begin
        $error("last_of_run: expected %0d, got %0d", t.last, out_mon.last_of_run);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_state   = stsc_pkg::MODE_IDLE;
      byte_pos     = '0;
      word_start   = '0;
      recent_chars = '0;
      overlong     = 1'b0;
      failures     = 0;
      due_tokens.delete();
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) scan_byte(in_mon.char_byte);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_token();
    end
    waiting_tokens <= due_tokens.size();
  end

endmodule

[tb/tb_source_token_scanner.sv]
// Testbench top for the source token scanner: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
module tb_source_token_scanner;

  localparam int ITEM_TARGET = 850;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 200;

  logic  clk;
  logic  rst_n;
  bit    tx_gaps;
  bit    rx_stalls;
  int    rx_hold;
  int    fed_items;
  int    failures;
  int    waiting_tokens;
  int    cycle_count;
  string punct_set  = ",.:;()[]{}!=-+*";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string blanks     = " \t\r\n";
  string keywords[4];

  stsc_in_if  in_ch();
  stsc_out_if out_ch();

  source_token_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stsc_token_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .failures       (failures),
    .waiting_tokens (waiting_tokens)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] rand_word_char();
    return word_chars[$urandom_range(0, word_chars.len() - 1)];
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fed_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // stop offering bytes until every predicted token has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting_tokens != 0) @(posedge clk);
  endtask

  // receiver: random stall per token, plus an occasional long hold-off
  initial begin
    int stall;
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold    = rx_hold;
      rx_hold = 0;
      stall   = rx_stalls ? $urandom_range(0, 10) : 0;
      if (hold + stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold + stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_source_token_scanner: done, errors");
    $finish;
  end

  initial begin
    int         pick;
    int         next_flip;
    string      word;
    logic [7:0] c;
    keywords  = '{"let", "return", "const", "use"};
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    rx_hold   = 0;
    fed_items = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // keywords glued to punctuation, empty string, illegal byte,
    // integer cut by end of input, unclosed string
    send_text("let+use*return-const!\"\"");
    send_byte(8'hFF);
    send_text("9");
    send_byte(stsc_pkg::CH_NUL);
    send_text("\"ab");
    send_byte(stsc_pkg::CH_NUL);

    // receiver holds off while bytes keep coming, so the input stalls
    wait_drained();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    rx_hold   = HOLD_CYCLES;
    repeat (30) send_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    wait_drained();

    tx_gaps   = 1'b1;
    next_flip = 100;
    while (fed_items < ITEM_TARGET) begin
      if (fed_items >= next_flip) begin
        next_flip += 100;
        tx_gaps   = 1'($urandom_range(0, 1));
        rx_stalls = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0) wait_drained();
      end
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1, 2: send_text(keywords[$urandom_range(0, 3)]);
        3, 4: begin
          word = keywords[$urandom_range(0, 3)];
          case ($urandom_range(0, 3))
            0: begin
              send_text(word);
              send_byte(rand_word_char());
            end
            1: send_text(word.substr(0, word.len() - 2));
            2: begin
              send_byte("_");
              send_text(word);
            end
            default: send_text(word.toupper());
          endcase
        end
        5, 6, 7: repeat ($urandom_range(1, 9)) send_byte(rand_word_char());
        8, 9: begin
          repeat ($urandom_range(1, 6)) begin
            c = "0";
            send_byte(c + 8'($urandom_range(0, 9)));
          end
        end
        10, 11: begin
          send_byte(stsc_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(1, 255)); while (c == stsc_pkg::CH_QUOTE);
            send_byte(c);
          end
          // sometimes the string is left open at end of input
          if ($urandom_range(0, 5) == 0) send_byte(stsc_pkg::CH_NUL);
          else send_byte(stsc_pkg::CH_QUOTE);
        end
        12, 13, 14, 15: send_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        16, 19: repeat ($urandom_range(1, 3)) send_byte(blanks[$urandom_range(0, 3)]);
        17: send_byte(8'($urandom_range(0, 255)));
        default: send_byte(stsc_pkg::CH_NUL);
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (failures == 0)
      $display("tb_source_token_scanner: done, clean");
    else
      $display("tb_source_token_scanner: done, errors");
    $finish;
  end

endmodule

[filelist.f]
sv/stsc_pkg.sv
sv/stsc_if.sv
sv/stsc_front.sv
sv/stsc_queue.sv
sv/stsc_back.sv
sv/source_token_scanner.sv
tb/stsc_token_checker.sv
tb/tb_source_token_scanner.sv
